>>> rtl/brqps_pkg.sv
package brqps_pkg;

	localparam int CFG_W  = 11;
	localparam int DATA_W = 32;
	localparam int POS_W  = 10;
	localparam int CAP_RST_VAL = 1024;

	localparam logic [2:0] CMD_PUSH  = 3'd0;
	localparam logic [2:0] CMD_PULL  = 3'd1;
	localparam logic [2:0] CMD_DROP  = 3'd2;
	localparam logic [2:0] CMD_PEEK  = 3'd3;
	localparam logic [2:0] CMD_FIND  = 3'd4;
	localparam logic [2:0] CMD_CLEAR = 3'd5;

	localparam logic [1:0] WS_BYTE = 2'd0;
	localparam logic [1:0] WS_HALF = 2'd1;
	localparam logic [1:0] WS_WORD = 2'd2;

	typedef struct packed {
		logic [2:0]        command;
		logic [DATA_W-1:0] data_in;
		logic [CFG_W-1:0]  drop_count;
		logic [POS_W-1:0]  offset;
		logic [1:0]        word_size;
	} in_item_t;

	typedef struct packed {
		logic              status;
		logic [DATA_W-1:0] data_out;
		logic              found;
		logic [POS_W-1:0]  match_position;
		logic [CFG_W-1:0]  fill_level;
		logic              is_empty;
		logic              is_full;
	} out_item_t;

	// controller -> datapath
	typedef struct packed {
		logic capture;
		logic exec;
		logic wait_rd;
		logic scan;
		logic load_out;
		logic cfg_wr;
	} ctl_cmd_t;

	// datapath -> controller
	typedef struct packed {
		logic go_wait;
		logic go_scan;
		logic scan_done;
	} ctl_sts_t;

endpackage

>>> rtl/byte_ring_queue_with_peek_search_unit.sv
// Sequence, accept to result beat: every command passes capture, execute and done; a pull
//   adds a read wait, and peek and find with a whole word from the offset add a byte scan
//   of the bytes from the offset (peek: the word; find: up to fill level or first match).
// Throughput: one command at a time; the single read port of
//   the byte store sets the one-byte-per-cycle scan rate of peek and find.
// Reset: pointers and fill level cleared, capacity min(1024, DEPTH), store left as is.
module byte_ring_queue_with_peek_search_unit import brqps_pkg::*; #(
	parameter int DEPTH = 1024
) (
	input  logic             clk,
	input  logic             arst_n,
	// command channel
	input  logic             in_valid,
	output logic             in_ready,
	input  in_item_t         in_payload,
	// result channel
	output logic             out_valid,
	input  logic             out_ready,
	output out_item_t        out_payload,
	// capacity register write
	input  logic             cfg_valid,
	output logic             cfg_ready,
	input  logic [CFG_W-1:0] cfg_data
);

	// The controller sequences each command (decode, optional read wait or
	// byte scan, then hand-off to the result register); the datapath holds the
	// ring pointers, the byte store and the scan window.
	// A capacity write also empties the queue.
	ctl_cmd_t ctl_cmd;
	ctl_sts_t ctl_sts;

	brqps_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.sts       (ctl_sts),
		.cmd       (ctl_cmd)
	);

	// Result beat sits in an output register, so a new command beat is taken
	// while the previous result is still waiting for the consumer.
	brqps_dp #(
		.DEPTH (DEPTH)
	) u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_payload  (in_payload),
		.cfg_data    (cfg_data),
		.cmd         (ctl_cmd),
		.sts         (ctl_sts),
		.out_payload (out_payload)
	);

endmodule

>>> rtl/brqps_ram.sv
module brqps_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 1024,
	localparam int AW = $clog2(DEPTH)
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic             re,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

>>> rtl/brqps_ctrl.sv
module brqps_ctrl import brqps_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     in_valid,
	output logic     in_ready,
	output logic     out_valid,
	input  logic     out_ready,
	input  logic     cfg_valid,
	output logic     cfg_ready,
	input  ctl_sts_t sts,
	output ctl_cmd_t cmd
);

	typedef enum logic [4:0] {
		ST_IDLE = 5'b00001,
		ST_EXEC = 5'b00010,
		ST_WAIT = 5'b00100,
		ST_SCAN = 5'b01000,
		ST_DONE = 5'b10000
	} state_t;

	state_t state_q, state_d;
	logic   out_valid_q;
	logic   slot_free;

	assign slot_free = !out_valid_q || out_ready;
	assign cfg_ready = (state_q == ST_IDLE);
	assign in_ready  = (state_q == ST_IDLE) && !cfg_valid;
	assign out_valid = out_valid_q;

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (in_valid && in_ready) begin
					state_d = ST_EXEC;
				end
			end
			ST_EXEC: begin
				if (sts.go_wait) begin
					state_d = ST_WAIT;
				end else if (sts.go_scan) begin
					state_d = ST_SCAN;
				end else begin
					state_d = ST_DONE;
				end
			end
			ST_WAIT: state_d = ST_DONE;
			ST_SCAN: begin
				if (sts.scan_done) begin
					state_d = ST_DONE;
				end
			end
			ST_DONE: begin
				if (slot_free) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		cmd.capture  = (state_q == ST_IDLE) && in_valid && in_ready;
		cmd.cfg_wr   = (state_q == ST_IDLE) && cfg_valid;
		cmd.exec     = (state_q == ST_EXEC);
		cmd.wait_rd  = (state_q == ST_WAIT);
		cmd.scan     = (state_q == ST_SCAN);
		cmd.load_out = (state_q == ST_DONE) && slot_free;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.load_out) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

endmodule

>>> rtl/brqps_dp.sv
module brqps_dp import brqps_pkg::*; #(
	parameter int DEPTH = 1024
) (
	input  logic             clk,
	input  logic             arst_n,
	input  in_item_t         in_payload,
	input  logic [CFG_W-1:0] cfg_data,
	input  ctl_cmd_t         cmd,
	output ctl_sts_t         sts,
	output out_item_t        out_payload
);

	localparam int PW = $clog2(DEPTH);
	localparam int CW = $clog2(DEPTH + 1);
	localparam int QW = (CW > CFG_W) ? CW : CFG_W;
	localparam int CAP_RST = (DEPTH < CAP_RST_VAL) ? DEPTH : CAP_RST_VAL;

	// queue state
	logic [CW-1:0] cap_q, cnt_q;
	logic [PW-1:0] rp_q, wp_q;
	in_item_t      item_q;

	// scan state
	logic [PW-1:0] addr_q;
	logic [QW-1:0] iss_pos_q, arr_pos_q, last_pos_q;
	logic [2:0]    got_q;
	logic [31:0]   win_q;
	logic          rd_valid_s1;

	// pending result
	logic              pend_fail_q, pend_found_q;
	logic [DATA_W-1:0] pend_data_q;
	logic [POS_W-1:0]  pend_pos_q;
	out_item_t         out_q;

	// ram
	logic          ram_we, ram_re;
	logic [PW-1:0] ram_raddr;
	logic [7:0]    ram_rdata;

	logic [2:0]    nb;
	logic          ws_bad, fits, fail, push_fail, pull_fail, drop_fail;
	logic [QW-1:0] cnt_x, cap_x, off_x, nb_x, drop_x, end_x, last_x, cfg_x, eff_x;
	logic [QW:0]   start_sum, start_w, drop_sum, drop_w;
	logic [PW-1:0] wp_inc, rp_inc, addr_inc;
	logic          issue, arrive, enough, hit, scan_done;
	logic [31:0]   win_new, word, target;
	logic [2:0]    got_new;
	logic [QW-1:0] hit_pos;

	assign cnt_x  = QW'(cnt_q);
	assign cap_x  = QW'(cap_q);
	assign off_x  = QW'(item_q.offset);
	assign nb_x   = QW'(nb);
	assign drop_x = QW'(item_q.drop_count);
	assign end_x  = off_x + nb_x;
	assign cfg_x  = QW'(cfg_data);

	always_comb begin
		case (item_q.word_size)
			WS_BYTE: nb = 3'd1;
			WS_HALF: nb = 3'd2;
			default: nb = 3'd4;
		endcase
	end

	assign ws_bad    = !(item_q.word_size == WS_BYTE || item_q.word_size == WS_HALF
		|| item_q.word_size == WS_WORD);
	assign fits      = end_x <= cnt_x;
	assign push_fail = cnt_x >= cap_x;
	assign pull_fail = (cnt_q == '0);
	assign drop_fail = drop_x > cnt_x;

	// clamp to 1..DEPTH
	assign eff_x = (cfg_x == '0) ? QW'(1) : ((cfg_x > QW'(DEPTH)) ? QW'(DEPTH) : cfg_x);

	// wrap adds: the pointer stays below the capacity and the offset or drop count at or below it, one subtract suffices
	assign start_sum = {1'b0, QW'(rp_q)} + {1'b0, off_x};
	assign start_w   = (start_sum >= {1'b0, cap_x}) ? start_sum - {1'b0, cap_x} : start_sum;
	assign drop_sum  = {1'b0, QW'(rp_q)} + {1'b0, drop_x};
	assign drop_w    = (drop_sum >= {1'b0, cap_x}) ? drop_sum - {1'b0, cap_x} : drop_sum;

	assign wp_inc   = (QW'(wp_q) + QW'(1) == cap_x) ? '0 : wp_q + PW'(1);
	assign rp_inc   = (QW'(rp_q) + QW'(1) == cap_x) ? '0 : rp_q + PW'(1);
	assign addr_inc = (QW'(addr_q) + QW'(1) == cap_x) ? '0 : addr_q + PW'(1);

	always_comb begin
		case (item_q.command)
			CMD_PUSH:  fail = push_fail;
			CMD_PULL:  fail = pull_fail;
			CMD_DROP:  fail = drop_fail;
			CMD_PEEK:  fail = ws_bad || !fits;
			CMD_FIND:  fail = ws_bad;
			CMD_CLEAR: fail = 1'b0;
			default:   fail = 1'b1;
		endcase
	end

	assign sts.go_wait = (item_q.command == CMD_PULL) && !pull_fail;
	assign sts.go_scan = (item_q.command == CMD_PEEK || item_q.command == CMD_FIND)
		&& !ws_bad && fits;
	assign last_x = (item_q.command == CMD_PEEK) ? end_x - QW'(1) : cnt_x - QW'(1);

	// byte-serial scan; the window keeps the newest byte on top
	assign issue   = cmd.scan && (iss_pos_q <= last_pos_q);
	assign arrive  = cmd.scan && rd_valid_s1;
	assign win_new = {ram_rdata, win_q[31:8]};
	assign got_new = (got_q == 3'd4) ? got_q : got_q + 3'd1;
	assign enough  = got_new >= nb;

	always_comb begin
		case (item_q.word_size)
			WS_BYTE: begin
				word   = {24'd0, win_new[31:24]};
				target = {24'd0, item_q.data_in[7:0]};
			end
			WS_HALF: begin
				word   = {16'd0, win_new[31:16]};
				target = {16'd0, item_q.data_in[15:0]};
			end
			default: begin
				word   = win_new;
				target = item_q.data_in;
			end
		endcase
	end

	assign hit       = (item_q.command == CMD_FIND) && enough && (word == target);
	assign scan_done = arrive && (hit || arr_pos_q == last_pos_q);
	assign hit_pos   = arr_pos_q - nb_x + QW'(1);
	assign sts.scan_done = scan_done;

	assign ram_we    = cmd.exec && (item_q.command == CMD_PUSH) && !push_fail;
	assign ram_re    = (cmd.exec && sts.go_wait) || issue;
	assign ram_raddr = cmd.exec ? rp_q : addr_q;

	brqps_ram #(
		.WIDTH (8),
		.DEPTH (DEPTH)
	) u_store (
		.clk   (clk),
		.we    (ram_we),
		.waddr (wp_q),
		.wdata (item_q.data_in[7:0]),
		.re    (ram_re),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	// control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cap_q       <= CW'(CAP_RST);
			cnt_q       <= '0;
			rp_q        <= '0;
			wp_q        <= '0;
			rd_valid_s1 <= 1'b0;
		end else begin
			rd_valid_s1 <= issue;
			if (cmd.cfg_wr) begin
				cap_q <= eff_x[CW-1:0];
				cnt_q <= '0;
				rp_q  <= '0;
				wp_q  <= '0;
			end else if (cmd.exec && !fail) begin
				case (item_q.command)
					CMD_PUSH: begin
						wp_q  <= wp_inc;
						cnt_q <= cnt_q + CW'(1);
					end
					CMD_PULL: begin
						rp_q  <= rp_inc;
						cnt_q <= cnt_q - CW'(1);
					end
					CMD_DROP: begin
						rp_q  <= drop_w[PW-1:0];
						cnt_q <= CW'(cnt_x - drop_x);
					end
					CMD_CLEAR: begin
						cnt_q <= '0;
						rp_q  <= '0;
						wp_q  <= '0;
					end
					default: ;
				endcase
			end
		end
	end

	// payload
	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			item_q <= in_payload;
		end
		if (cmd.exec) begin
			pend_fail_q  <= fail;
			pend_data_q  <= '0;
			pend_found_q <= 1'b0;
			pend_pos_q   <= '0;
			addr_q       <= start_w[PW-1:0];
			iss_pos_q    <= off_x;
			arr_pos_q    <= off_x;
			last_pos_q   <= last_x;
			got_q        <= '0;
		end
		if (cmd.wait_rd) begin
			pend_data_q <= {24'd0, ram_rdata};
		end
		if (issue) begin
			addr_q    <= addr_inc;
			iss_pos_q <= iss_pos_q + QW'(1);
		end
		if (arrive) begin
			win_q     <= win_new;
			got_q     <= got_new;
			arr_pos_q <= arr_pos_q + QW'(1);
		end
		if (scan_done) begin
			pend_data_q  <= (item_q.command == CMD_PEEK) ? word : '0;
			pend_found_q <= hit;
			pend_pos_q   <= hit ? hit_pos[POS_W-1:0] : '0;
		end
		if (cmd.load_out) begin
			out_q.status         <= pend_fail_q;
			out_q.data_out       <= pend_data_q;
			out_q.found          <= pend_found_q;
			out_q.match_position <= pend_pos_q;
			out_q.fill_level     <= cnt_x[CFG_W-1:0];
			out_q.is_empty       <= (cnt_q == '0);
			out_q.is_full        <= (cnt_q == cap_q);
		end
	end

	assign out_payload = out_q;

endmodule

>>> tb/sv/tb_top.sv
module tb_top;
	timeunit 1ns;
	timeprecision 1ps;

	import brqps_pkg::*;

	localparam int RING_DEPTH = 1024;
	localparam int SLOT_W     = $clog2(RING_DEPTH);

	// commands 6 and 7 are not decoded; the block must fail them
	localparam logic [2:0] CMD_SPARE6 = 3'd6;
	localparam logic [2:0] CMD_SPARE7 = 3'd7;
	// word size code with no width behind it
	localparam logic [1:0] WS_BAD = 2'd3;

	localparam int PHASES          = 15;
	localparam int ITEMS_PER_PHASE = 122;
	// receiver hold-offs: long enough for the block to sit on a result and refuse input
	localparam int HOLD_CYCLES = 400;
	localparam int HOLD_AT_A   = 90;
	localparam int HOLD_AT_B   = 900;
	localparam int DRAIN_TAIL  = RING_DEPTH + 16;
	// worst case per beat: both gaps, a full-depth scan and the fixed overhead; then x3
	localparam longint CYCLE_LIMIT =
		64'd1900 * (19 + 19 + 8 + RING_DEPTH) * 3 + 2 * HOLD_CYCLES + 64'd10000;

	// Mirror of the ring: byte slots, head/tail, fill and effective capacity,
	// plus the queue of results still owed by the block.
	class ring_mirror;
		logic [7:0]  slots [RING_DEPTH];
		int unsigned head, tail, fill, cap;
		out_item_t   expected_results [$];
		int unsigned errors;

		function new();
			head   = 0;
			tail   = 0;
			fill   = 0;
			cap    = (CAP_RST_VAL > RING_DEPTH) ? RING_DEPTH : CAP_RST_VAL;
			errors = 0;
		endfunction

		// capacity write also empties the queue
		function void set_capacity(logic [CFG_W-1:0] value);
			if (value == 0)
				cap = 1;
			else if (32'(value) > RING_DEPTH)
				cap = RING_DEPTH;
			else
				cap = 32'(value);
			head = 0;
			tail = 0;
			fill = 0;
		endfunction

		// little-endian word of nbytes, pos bytes past the head
		function logic [DATA_W-1:0] word_at(int unsigned pos, int unsigned nbytes);
			logic [DATA_W-1:0] w;
			w = '0;
			for (int unsigned k = 0; k < nbytes; k++)
				w[8*k +: 8] = slots[SLOT_W'((head + pos + k) % cap)];
			return w;
		endfunction

		function void note_command(in_item_t c);
			out_item_t         e;
			int unsigned       nbytes, off, drop;
			logic [DATA_W-1:0] mask, target;
			e      = '0;
			nbytes = (c.word_size == WS_BYTE) ? 1 : (c.word_size == WS_HALF) ? 2 : 4;
			off    = 32'(c.offset);
			drop   = 32'(c.drop_count);
			case (c.command)
				CMD_PUSH: begin
					if (fill >= cap) begin
						e.status = 1'b1;
					end else begin
						slots[SLOT_W'(tail)] = c.data_in[7:0];
						tail = (tail + 1) % cap;
						fill++;
					end
				end
				CMD_PULL: begin
					if (fill == 0) begin
						e.status = 1'b1;
					end else begin
						e.data_out = {24'd0, slots[SLOT_W'(head)]};
						head = (head + 1) % cap;
						fill--;
					end
				end
				CMD_DROP: begin
					if (drop > fill) begin
						e.status = 1'b1;
					end else begin
						head = (head + drop) % cap;
						fill -= drop;
					end
				end
				CMD_PEEK: begin
					if (c.word_size == WS_BAD || off + nbytes > fill)
						e.status = 1'b1;
					else
						e.data_out = word_at(off, nbytes);
				end
				CMD_FIND: begin
					if (c.word_size == WS_BAD) begin
						e.status = 1'b1;
					end else begin
						mask   = (nbytes == 4) ? '1 : ((32'd1 << (8 * nbytes)) - 1);
						target = c.data_in & mask;
						for (int unsigned i = off; i + nbytes <= fill; i++) begin
							if (word_at(i, nbytes) == target) begin
								e.found          = 1'b1;
								e.match_position = i[POS_W-1:0];
								break;
							end
						end
					end
				end
				CMD_CLEAR: begin
					head = 0;
					tail = 0;
					fill = 0;
				end
				default: e.status = 1'b1;
			endcase
			e.fill_level = fill[CFG_W-1:0];
			e.is_empty   = (fill == 0);
			e.is_full    = (fill == cap);
			expected_results.push_back(e);
		endfunction

		function void compare(string field, logic [DATA_W-1:0] want, logic [DATA_W-1:0] got);
			if (want !== got) begin
				$error("%s: expected 0x%0h, got 0x%0h", field, want, got);
				errors++;
			end
		endfunction

		function void check_result(out_item_t got);
			out_item_t e;
			if (expected_results.size() == 0) begin
				$error("result beat with no command outstanding");
				errors++;
				return;
			end
			e = expected_results.pop_front();
			compare("status", DATA_W'(e.status), DATA_W'(got.status));
			compare("data_out", e.data_out, got.data_out);
			compare("found", DATA_W'(e.found), DATA_W'(got.found));
			compare("match_position", DATA_W'(e.match_position),
				DATA_W'(got.match_position));
			compare("fill_level", DATA_W'(e.fill_level), DATA_W'(got.fill_level));
			compare("is_empty", DATA_W'(e.is_empty), DATA_W'(got.is_empty));
			compare("is_full", DATA_W'(e.is_full), DATA_W'(got.is_full));
		endfunction
	endclass

	logic             clk;
	logic             arst_n;
	logic             in_valid;
	logic             in_ready;
	in_item_t         in_payload;
	logic             out_valid;
	logic             out_ready;
	out_item_t        out_payload;
	logic             cfg_valid;
	logic             cfg_ready;
	logic [CFG_W-1:0] cfg_data;

	ring_mirror  mirror = new();
	int unsigned commands_sent = 0;
	longint      cycles = 0;

	byte_ring_queue_with_peek_search_unit #(
		.DEPTH(RING_DEPTH)
	) dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.in_payload (in_payload),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.out_payload(out_payload),
		.cfg_valid  (cfg_valid),
		.cfg_ready  (cfg_ready),
		.cfg_data   (cfg_data)
	);

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	// Watchdog: a stuck handshake or a lost result ends here.
	initial begin : watchdog
		while (cycles < CYCLE_LIMIT) begin
			@(posedge clk);
			cycles++;
		end
		$display("CHECKS FAILED");
		$finish;
	end

	function automatic in_item_t make_item(logic [2:0] op, logic [DATA_W-1:0] data,
			logic [CFG_W-1:0] drop, logic [POS_W-1:0] off, logic [1:0] ws);
		in_item_t c;
		c.command    = op;
		c.data_in    = data;
		c.drop_count = drop;
		c.offset     = off;
		c.word_size  = ws;
		return c;
	endfunction

	// Mostly well-formed commands against the current fill: drops that fit,
	// peeks inside the data, finds whose target is lifted from queued bytes.
	// The rest keep the fully random fields as noise.
	function automatic in_item_t random_command();
		in_item_t          c;
		int unsigned       pick, nbytes, fill, p;
		logic [DATA_W-1:0] mask;
		fill         = mirror.fill;
		c.command    = CMD_PUSH;
		c.data_in    = $urandom();
		c.drop_count = CFG_W'($urandom_range(0, 2047));
		c.offset     = POS_W'($urandom_range(0, 1023));
		c.word_size  = 2'($urandom_range(0, 3));
		pick         = $urandom_range(0, 99);
		if (pick < 35) begin
			c.command = CMD_PUSH;
		end else if (pick < 50) begin
			c.command = CMD_PULL;
		end else if (pick < 60) begin
			c.command = CMD_DROP;
			if ($urandom_range(0, 3) != 0)
				c.drop_count = CFG_W'($urandom_range(0, fill));
		end else if (pick < 76) begin
			c.command = CMD_PEEK;
			if ($urandom_range(0, 4) != 0) begin
				c.word_size = 2'($urandom_range(0, 2));
				nbytes = 1 << c.word_size;
				if (fill >= nbytes)
					c.offset = POS_W'($urandom_range(0, fill - nbytes));
			end
		end else if (pick < 93) begin
			c.command = CMD_FIND;
			if ($urandom_range(0, 4) != 0) begin
				c.word_size = 2'($urandom_range(0, 2));
				nbytes = 1 << c.word_size;
				c.offset = POS_W'((fill > 1023) ? $urandom_range(0, 1023)
					: $urandom_range(0, fill));
				if (32'(c.offset) + nbytes <= fill && $urandom_range(0, 2) != 0) begin
					p    = $urandom_range(32'(c.offset), fill - nbytes);
					mask = (nbytes == 4) ? '1 : ((32'd1 << (8 * nbytes)) - 1);
					// junk above the compared bytes must be ignored
					c.data_in = (mirror.word_at(p, nbytes) & mask) | (c.data_in & ~mask);
				end
			end
		end else if (pick < 97) begin
			c.command = CMD_CLEAR;
		end else begin
			c.command = $urandom_range(0, 1) ? CMD_SPARE6 : CMD_SPARE7;
		end
		return c;
	endfunction

	// Offer one command beat after a random gap; runs of back-to-back beats too.
	task automatic send_command(input in_item_t c);
		int unsigned gap;
		gap = (commands_sent % 50 < 15) ? 0 : $urandom_range(0, 19);
		repeat (gap) begin
			@(negedge clk);
			in_valid <= 1'b0;
		end
		@(negedge clk);
		in_payload <= c;
		in_valid   <= 1'b1;
		do @(posedge clk); while (!(in_valid && in_ready));
		mirror.note_command(c);
		commands_sent++;
	endtask

	task automatic wait_drained();
		@(negedge clk);
		in_valid <= 1'b0;
		while (mirror.expected_results.size() != 0)
			@(posedge clk);
	endtask

	// Only called with the block idle: every command has been answered.
	task automatic write_capacity(input logic [CFG_W-1:0] value);
		@(negedge clk);
		cfg_data  <= value;
		cfg_valid <= 1'b1;
		do @(posedge clk); while (!(cfg_valid && cfg_ready));
		mirror.set_capacity(value);
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	// Result side: random stalls per beat, quiet stretches, and two long
	// hold-offs so the block fills its output and stops taking commands.
	initial begin : result_sink
		int unsigned gap;
		int unsigned taken;
		taken = 0;
		wait (arst_n === 1'b1);
		forever begin
			if (taken == HOLD_AT_A || taken == HOLD_AT_B)
				gap = HOLD_CYCLES;
			else if (taken % 40 >= 28)
				gap = 0;
			else
				gap = $urandom_range(0, 19);
			repeat (gap) begin
				@(negedge clk);
				out_ready <= 1'b0;
			end
			@(negedge clk);
			out_ready <= 1'b1;
			do @(posedge clk); while (!(out_valid && out_ready));
			mirror.check_result(out_payload);
			taken++;
		end
	end

	initial begin : stimulus
		logic [CFG_W-1:0] phase_cap;
		arst_n     = 1'b0;
		in_valid   = 1'b0;
		in_payload = '0;
		out_ready  = 1'b0;
		cfg_valid  = 1'b0;
		cfg_data   = '0;
		repeat (10) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// Directed, reset capacity: everything fails or answers sensibly on an empty ring
		send_command(make_item(CMD_PULL, '0, '0, '0, WS_BYTE));          // pull when empty
		send_command(make_item(CMD_DROP, '0, 11'd1, '0, WS_BYTE));       // drop more than queued
		send_command(make_item(CMD_DROP, '0, 11'd0, '0, WS_BYTE));       // drop of nothing is fine
		send_command(make_item(CMD_PEEK, '0, '0, '0, WS_BYTE));          // peek beyond the data
		send_command(make_item(CMD_FIND, '0, '0, '0, WS_BYTE));          // find, nothing queued
		send_command(make_item(CMD_SPARE6, '1, '1, '1, WS_WORD));        // unused commands
		send_command(make_item(CMD_SPARE7, '1, '1, '1, WS_WORD));
		send_command(make_item(CMD_PUSH, 32'hFFFF_FFFF, '1, '1, WS_BAD));
		send_command(make_item(CMD_PUSH, 32'h0000_0000, '0, '0, WS_BYTE));
		send_command(make_item(CMD_PEEK, '0, '0, 10'd0, WS_HALF));       // 0x00ff
		send_command(make_item(CMD_PEEK, '0, '0, 10'd1023, WS_WORD));    // offset at its top
		send_command(make_item(CMD_PEEK, '0, '0, 10'd0, WS_BAD));        // bad word size
		send_command(make_item(CMD_FIND, '0, '0, 10'd0, WS_BAD));
		send_command(make_item(CMD_FIND, 32'hABCD_EF00, '0, 10'd0, WS_BYTE)); // upper bits ignored
		send_command(make_item(CMD_FIND, 32'h0000_00FF, '0, 10'd1023, WS_BYTE)); // start past data
		send_command(make_item(CMD_DROP, '0, 11'd2047, '0, WS_BYTE));
		send_command(make_item(CMD_CLEAR, '0, '0, '0, WS_BYTE));
		wait_drained();

		// Directed, capacity 4: full ring, wrap-around in peek and find
		write_capacity(11'd4);
		send_command(make_item(CMD_PUSH, 32'h11, '0, '0, WS_BYTE));
		send_command(make_item(CMD_PUSH, 32'h22, '0, '0, WS_BYTE));
		send_command(make_item(CMD_PUSH, 32'h33, '0, '0, WS_BYTE));
		send_command(make_item(CMD_PUSH, 32'h44, '0, '0, WS_BYTE));
		send_command(make_item(CMD_PUSH, 32'h55, '0, '0, WS_BYTE));      // push when full
		send_command(make_item(CMD_PULL, '0, '0, '0, WS_BYTE));
		send_command(make_item(CMD_PUSH, 32'h66, '0, '0, WS_BYTE));      // lands in slot 0
		send_command(make_item(CMD_PEEK, '0, '0, 10'd0, WS_WORD));       // 0x66443322
		send_command(make_item(CMD_FIND, 32'h6644, '0, 10'd0, WS_HALF)); // match straddles wrap
		send_command(make_item(CMD_DROP, '0, 11'd4, '0, WS_BYTE));

		// Random phases: extremes of the capacity, the rest small so rings wrap often
		for (int p = 0; p < PHASES; p++) begin
			case (p)
				0:       phase_cap = 11'd0;     // behaves as 1
				1:       phase_cap = 11'd1;
				2:       phase_cap = 11'd2047;  // clamps to the depth
				4:       phase_cap = 11'd1023;
				5:       phase_cap = 11'd2;
				6:       phase_cap = 11'd1024;
				8:       phase_cap = 11'd3;
				9:       phase_cap = 11'd5;
				10:      phase_cap = 11'd16;
				12:      phase_cap = 11'd64;
				default: phase_cap = CFG_W'($urandom_range(2, 96));
			endcase
			wait_drained();
			write_capacity(phase_cap);
			repeat (ITEMS_PER_PHASE)
				send_command(random_command());
		end

		wait_drained();
		// room for any stray beat to show up
		repeat (DRAIN_TAIL) @(posedge clk);
		if (mirror.errors == 0)
			$display("ALL CHECKS PASSED");
		else
			$display("CHECKS FAILED");
		$finish;
	end

endmodule

>>> sim.f
rtl/brqps_pkg.sv
rtl/brqps_ram.sv
rtl/brqps_ctrl.sv
rtl/brqps_dp.sv
rtl/byte_ring_queue_with_peek_search_unit.sv
tb/sv/tb_top.sv
